[hw/rtl/rbws_pkg.sv]
// ----------------------------------------------------------------------------
// Replica bid window selector package
// Shared constants, state type and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package rbws_pkg;

    localparam int MAX_BIDS_DEF     = 16;
    localparam int MAX_REPLICAS_DEF = 8;

    localparam logic CFG_REPLICA_COUNT     = 1'b0;
    localparam logic CFG_TRANSFER_DURATION = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SPAN,
        ST_WIN,
        ST_SORT,
        ST_DEPTH,
        ST_EMIT,
        ST_FAIL
    } state_t;

    // commands from the controller
    typedef struct packed {
        logic store_bid;
        logic shift_step;
        logic span_init;
        logic span_step;
        logic win_init;
        logic win_step;
        logic sort_init;
        logic sort_step;
        logic depth_init;
        logic depth_step;
        logic emit_init;
        logic emit_step;
        logic fail_out;
        logic clear_count;
    } cmd_t;

    // status back to the controller
    typedef struct packed {
        logic shift_done;
        logic span_done;
        logic win_done;
        logic win_ok;
        logic sort_done;
        logic depth_done;
        logic emit_last;
    } status_t;

endpackage

[hw/rtl/replica_bid_window_selector_top.sv]
// A bid enters from the top of the sorted store and shifts down past each later start.
// Selection after the last bid: a span search, a window walk, an index insertion sort,
// a depth pass, then one result per cycle.
// The sequencer handles one item at a time; busy is high throughout.
// Reset: rst_n asynchronous; replica_count 3, duration 0, store empty.
// Results carry no back-pressure: done marks each for one cycle.
module replica_bid_window_selector_top
#(
    parameter int MAX_BIDS     = rbws_pkg::MAX_BIDS_DEF,
    parameter int MAX_REPLICAS = rbws_pkg::MAX_REPLICAS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] bid_open,
    input  logic [47:0] bid_end,
    input  logic [47:0] ack_estimate,
    input  logic [15:0] target_id,
    input  logic [9:0]  backlog,
    input  logic        last_bid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [15:0] chosen_target,
    output logic [47:0] window_begin,
    output logic [48:0] window_finish,
    output logic [9:0]  max_depth,
    output logic        found,
    output logic        last_result
);
    import rbws_pkg::*;

    cmd_t        cmd;
    status_t     sts;
    logic [3:0]  rc_reg;
    logic [31:0] td_reg;

    assign cfg_ready = 1'b1;

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= 4'd3;
            td_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REPLICA_COUNT:     rc_reg <= cfg_data[3:0];
                CFG_TRANSFER_DURATION: td_reg <= cfg_data;
                default:               rc_reg <= rc_reg;
            endcase
        end
    end

    rbws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_bid (last_bid),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    rbws_dp #(.MAX_BIDS(MAX_BIDS), .MAX_REPLICAS(MAX_REPLICAS)) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .replica_count     (rc_reg),
        .transfer_duration (td_reg),
        .bid_open          (bid_open),
        .bid_end           (bid_end),
        .ack_estimate      (ack_estimate),
        .target_id         (target_id),
        .backlog           (backlog),
        .done              (done),
        .chosen_target     (chosen_target),
        .window_begin      (window_begin),
        .window_finish     (window_finish),
        .max_depth         (max_depth),
        .found             (found),
        .last_result       (last_result)
    );

endmodule

[hw/rtl/rbws_ctrl.sv]
// ----------------------------------------------------------------------------
// Replica bid window selector controller
// Sequences insertion, span search, window walk, ack sort, depth pass and result or failure output.
// ----------------------------------------------------------------------------
module rbws_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_bid,
    input  rbws_pkg::status_t sts,
    output rbws_pkg::cmd_t    cmd,
    output logic              busy
);
    import rbws_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_INSERT;
                    last_next  = last_bid;
                end
            end
            ST_INSERT:
            begin
                if (sts.shift_done)
                    state_next = last_reg ? ST_SPAN : ST_IDLE;
            end
            ST_SPAN:
            begin
                if (sts.span_done)
                    state_next = ST_WIN;
            end
            ST_WIN:
            begin
                if (sts.win_done)
                    state_next = sts.win_ok ? ST_SORT : ST_FAIL;
            end
            ST_SORT:
            begin
                if (sts.sort_done)
                    state_next = ST_DEPTH;
            end
            ST_DEPTH:
            begin
                if (sts.depth_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.emit_last)
                    state_next = ST_IDLE;
            end
            ST_FAIL:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:   cmd.store_bid  = start;
            ST_INSERT:
            begin
                cmd.shift_step = 1'b1;
                cmd.span_init  = sts.shift_done & last_reg;
            end
            ST_SPAN:
            begin
                cmd.span_step = 1'b1;
                cmd.win_init  = sts.span_done;
            end
            ST_WIN:
            begin
                cmd.win_step  = 1'b1;
                cmd.sort_init = sts.win_done;
            end
            ST_SORT:
            begin
                cmd.sort_step  = 1'b1;
                cmd.depth_init = sts.sort_done;
            end
            ST_DEPTH:
            begin
                cmd.depth_step = 1'b1;
                cmd.emit_init  = sts.depth_done;
            end
            ST_EMIT:
            begin
                cmd.emit_step   = 1'b1;
                cmd.clear_count = sts.emit_last;
            end
            ST_FAIL:
            begin
                cmd.fail_out    = 1'b1;
                cmd.clear_count = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[hw/rtl/rbws_dp.sv]
// ----------------------------------------------------------------------------
// Replica bid window selector datapath
// Sorted bid store with shift insertion, span search, window walk, ack-order
// insertion sort on an index list, depth pass and result registers.
// ----------------------------------------------------------------------------
module rbws_dp
#(
    parameter int MAX_BIDS     = rbws_pkg::MAX_BIDS_DEF,
    parameter int MAX_REPLICAS = rbws_pkg::MAX_REPLICAS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rbws_pkg::cmd_t    cmd,
    output rbws_pkg::status_t sts,
    input  logic [3:0]        replica_count,
    input  logic [31:0]       transfer_duration,
    input  logic [47:0]       bid_open,
    input  logic [47:0]       bid_end,
    input  logic [47:0]       ack_estimate,
    input  logic [15:0]       target_id,
    input  logic [9:0]        backlog,
    output logic              done,
    output logic [15:0]       chosen_target,
    output logic [47:0]       window_begin,
    output logic [48:0]       window_finish,
    output logic [9:0]        max_depth,
    output logic              found,
    output logic              last_result
);
    import rbws_pkg::*;

    localparam int IW = $clog2(MAX_BIDS);
    localparam int CW = $clog2(MAX_BIDS + 1);
    localparam int RW = $clog2(MAX_REPLICAS + 1);

    // bid store (shift line, entries read by index)
    logic [47:0] st_reg  [MAX_BIDS];
    logic [47:0] en_reg  [MAX_BIDS];
    logic [47:0] ak_reg  [MAX_BIDS];
    logic [15:0] tg_reg  [MAX_BIDS];
    logic [9:0]  dp_reg  [MAX_BIDS];
    logic [IW-1:0] ord_reg [MAX_BIDS];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [47:0]   in_s_reg, in_e_reg, in_a_reg;
    logic [15:0]   in_t_reg;
    logic [9:0]    in_d_reg;
    logic          in_full_reg;

    logic [RW-1:0] r_eff;
    always_comb
    begin
        if (replica_count == 4'd0)
            r_eff = RW'(1);
        else if (32'(replica_count) > MAX_REPLICAS)
            r_eff = RW'(MAX_REPLICAS);
        else
            r_eff = RW'(replica_count);
    end

    // insertion walks from the top down, one slot per cycle
    logic          ins_here;
    logic [IW-1:0] p_lo;
    assign p_lo     = IW'(ptr_reg - CW'(1));
    assign ins_here = (ptr_reg == '0) || (st_reg[p_lo] <= in_s_reg);
    assign sts.shift_done = in_full_reg || ins_here;

    always_ff @(posedge clk)
    begin
        if (cmd.store_bid)
        begin
            in_s_reg <= bid_open;
            in_e_reg <= bid_end;
            in_a_reg <= ack_estimate;
            in_t_reg <= target_id;
            in_d_reg <= backlog;
        end
        else if (cmd.shift_step && !in_full_reg)
        begin
            if (ins_here)
            begin
                st_reg[IW'(ptr_reg)] <= in_s_reg;
                en_reg[IW'(ptr_reg)] <= in_e_reg;
                ak_reg[IW'(ptr_reg)] <= in_a_reg;
                tg_reg[IW'(ptr_reg)] <= in_t_reg;
                dp_reg[IW'(ptr_reg)] <= in_d_reg;
            end
            else
            begin
                st_reg[IW'(ptr_reg)] <= st_reg[p_lo];
                en_reg[IW'(ptr_reg)] <= en_reg[p_lo];
                ak_reg[IW'(ptr_reg)] <= ak_reg[p_lo];
                tg_reg[IW'(ptr_reg)] <= tg_reg[p_lo];
                dp_reg[IW'(ptr_reg)] <= dp_reg[p_lo];
            end
        end
    end

    // span search, window walk, sort, depth and emit
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [IW-1:0] base_reg;
    logic [47:0]   best_reg;
    logic          best_v_reg;
    logic [47:0]   wb_reg, we_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] v_reg;
    logic          hold_reg;
    logic [9:0]    maxd_reg;
    logic [RW-1:0] e_reg;

    logic [CW-1:0] hi_idx;
    logic [47:0]   span;
    assign hi_idx = i_reg + CW'(r_eff) - CW'(1);
    assign span   = st_reg[IW'(hi_idx)] - st_reg[IW'(i_reg)];
    assign sts.span_done = (hi_idx >= count_reg);

    logic [CW-1:0] k_idx;
    logic [47:0]   ks;
    logic [48:0]   lim;
    logic          stop;
    assign k_idx = CW'(base_reg) + cnt_reg;
    assign ks    = st_reg[IW'(k_idx)];
    assign lim   = {1'b0, wb_reg} + 49'(transfer_duration);
    assign stop  = (k_idx >= count_reg) || (ks > we_reg) ||
                   ((cnt_reg >= CW'(r_eff)) && ({1'b0, ks} > lim));
    assign sts.win_done = stop;
    assign sts.win_ok   = (count_reg >= CW'(r_eff)) && (cnt_reg >= CW'(r_eff));

    // sort: i_reg outer, j_reg inner position, v_reg element being placed
    logic          no_sort;
    logic [IW-1:0] jm1;
    logic          move;
    assign no_sort = (cnt_reg <= CW'(r_eff));
    assign jm1     = IW'(j_reg - CW'(1));
    assign move    = (j_reg != '0) && (ak_reg[ord_reg[jm1]] > ak_reg[v_reg]);
    assign sts.sort_done = no_sort || (i_reg >= cnt_reg);
    assign sts.depth_done = (e_reg >= RW'(r_eff - RW'(1)));
    assign sts.emit_last  = (e_reg >= RW'(r_eff - RW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            in_full_reg <= 1'b0;
            done        <= 1'b0;
            found       <= 1'b0;
            last_result <= 1'b0;
            hold_reg    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            // take bid
            if (cmd.store_bid)
            begin
                ptr_reg     <= count_reg;
                in_full_reg <= (count_reg >= CW'(MAX_BIDS));
            end
            // advance insertion
            if (cmd.shift_step)
            begin
                if (!in_full_reg && ins_here)
                    count_reg <= count_reg + CW'(1);
                else if (!in_full_reg)
                    ptr_reg <= ptr_reg - CW'(1);
            end
            if (cmd.span_init)
            begin
                i_reg      <= '0;
                best_v_reg <= 1'b0;
                base_reg   <= '0;
            end
            // scan spans
            if (cmd.span_step && (hi_idx < count_reg))
            begin
                if (!best_v_reg || span < best_reg)
                begin
                    best_reg   <= span;
                    best_v_reg <= 1'b1;
                    base_reg   <= IW'(i_reg);
                end
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.win_init)
            begin
                wb_reg  <= st_reg[base_reg];
                we_reg  <= en_reg[base_reg];
                cnt_reg <= '0;
            end
            // extend window
            if (cmd.win_step && !stop)
            begin
                if (ks > wb_reg)
                    wb_reg <= ks;
                if (en_reg[IW'(k_idx)] < we_reg)
                    we_reg <= en_reg[IW'(k_idx)];
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.sort_init)
            begin
                for (int q = 0; q < MAX_BIDS; q++)
                    ord_reg[q] <= base_reg + IW'(q);
                i_reg    <= CW'(1);
                hold_reg <= 1'b0;
            end
            // insertion sort of indexes by ack, at most one move per cycle
            if (cmd.sort_step && !sts.sort_done)
            begin
                if (!hold_reg)
                begin
                    v_reg    <= ord_reg[IW'(i_reg)];
                    j_reg    <= i_reg;
                    hold_reg <= 1'b1;
                end
                else if (move)
                begin
                    ord_reg[IW'(j_reg)] <= ord_reg[jm1];
                    j_reg <= j_reg - CW'(1);
                end
                else
                begin
                    ord_reg[IW'(j_reg)] <= v_reg;
                    i_reg    <= i_reg + CW'(1);
                    hold_reg <= 1'b0;
                end
            end
            if (cmd.depth_init)
            begin
                e_reg    <= RW'(1);
                maxd_reg <= dp_reg[ord_reg[0]];
            end
            else if (cmd.depth_step)
            begin
                e_reg <= e_reg + RW'(1);
                if (e_reg < r_eff && dp_reg[ord_reg[IW'(e_reg)]] > maxd_reg)
                    maxd_reg <= dp_reg[ord_reg[IW'(e_reg)]];
            end
            if (r_eff == RW'(1) && cmd.depth_init)
                e_reg <= '0;
            if (cmd.emit_init)
                e_reg <= '0;
            // drive one result
            if (cmd.emit_step)
            begin
                done            <= 1'b1;
                found           <= 1'b1;
                last_result     <= sts.emit_last;
                chosen_target   <= tg_reg[ord_reg[IW'(e_reg)]];
                window_begin    <= wb_reg;
                window_finish   <= lim;
                max_depth       <= maxd_reg;
                e_reg           <= e_reg + RW'(1);
            end
            if (cmd.fail_out)
            begin
                done            <= 1'b1;
                found           <= 1'b0;
                last_result     <= 1'b1;
                chosen_target   <= '0;
                window_begin    <= '0;
                window_finish   <= '0;
                max_depth       <= '0;
            end
            if (cmd.clear_count)
                count_reg <= '0;
        end
    end

endmodule

[bench/replica_bid_window_selector_top_test.sv]
// ----------------------------------------------------------------------------
// Replica bid window selector testbench
// Drives groups of bids through the command port, writes both registers
// between phases, predicts every selection result and checks each one as it
// is strobed out.
// ----------------------------------------------------------------------------
module replica_bid_window_selector_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rbws_pkg::*;

    typedef struct {
        logic [15:0] target;
        logic [47:0] wbegin;
        logic [48:0] wfinish;
        logic [9:0]  depth;
        logic        found;
        logic        last;
    } sel_result_t;

    // Small scoreboard: own copy of the bid store and the registers
    class bid_scoreboard;
        logic [3:0]  replicas;
        logic [31:0] duration;
        logic [47:0] starts [MAX_BIDS_DEF];
        logic [47:0] ends   [MAX_BIDS_DEF];
        logic [47:0] acks   [MAX_BIDS_DEF];
        logic [15:0] targets[MAX_BIDS_DEF];
        logic [9:0]  depths [MAX_BIDS_DEF];
        int          count;
        sel_result_t pending[$];
        int          errors;

        function new();
            replicas = 4'd3;
            duration = '0;
            count    = 0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == CFG_REPLICA_COUNT)
                replicas = value[3:0];
            else
                duration = value;
        endfunction

        // Produce the expected results of one closed group
        function void select_window();
            int          r;
            int          base;
            int          cnt;
            int          v;
            int          j;
            int          order[MAX_BIDS_DEF];
            logic [63:0] best;
            logic [63:0] span;
            logic [47:0] wb;
            logic [47:0] we;
            logic [9:0]  maxd;
            sel_result_t res;

            r    = (replicas == 0) ? 1 : ((replicas > MAX_REPLICAS_DEF) ?
                   MAX_REPLICAS_DEF : int'(replicas));
            base = 0;
            cnt  = 0;
            best = '1;
            maxd = '0;
            if (count >= r) begin
                for (int i = 0; i + r - 1 < count; i++) begin
                    span = {16'd0, starts[i + r - 1] - starts[i]};
                    if (span < best) begin
                        best = span;
                        base = i;
                    end
                end
                wb = starts[base];
                we = ends[base];
                for (int k = base; k < count; k++) begin
                    if (starts[k] > we)
                        break;
                    if (cnt >= r && {1'b0, starts[k]} > {1'b0, wb} + duration)
                        break;
                    if (starts[k] > wb)
                        wb = starts[k];
                    if (ends[k] < we)
                        we = ends[k];
                    cnt++;
                end
            end
            if (count < r || cnt < r) begin
                res = '{16'd0, 48'd0, 49'd0, 10'd0, 1'b0, 1'b1};
                pending.push_back(res);
                return;
            end
            for (int i = 0; i < cnt; i++)
                order[i] = base + i;
            // stable ack ordering only when more comply than needed
            if (cnt > r) begin
                for (int i = 1; i < cnt; i++) begin
                    v = order[i];
                    j = i;
                    while (j > 0 && acks[order[j - 1]] > acks[v]) begin
                        order[j] = order[j - 1];
                        j--;
                    end
                    order[j] = v;
                end
            end
            for (int i = 0; i < r; i++)
                if (depths[order[i]] > maxd)
                    maxd = depths[order[i]];
            for (int i = 0; i < r; i++) begin
                res.target  = targets[order[i]];
                res.wbegin  = wb;
                res.wfinish = {1'b0, wb} + duration;
                res.depth   = maxd;
                res.found   = 1'b1;
                res.last    = (i + 1 == r);
                pending.push_back(res);
            end
        endfunction

        function void note_bid(logic [47:0] s, logic [47:0] e, logic [47:0] a,
                               logic [15:0] t, logic [9:0] d, logic lst);
            int pos;

            pos = 0;
            if (count < MAX_BIDS_DEF) begin
                while (pos < count && starts[pos] <= s)
                    pos++;
                for (int k = count; k > pos; k--) begin
                    starts[k]  = starts[k - 1];
                    ends[k]    = ends[k - 1];
                    acks[k]    = acks[k - 1];
                    targets[k] = targets[k - 1];
                    depths[k]  = depths[k - 1];
                end
                starts[pos]  = s;
                ends[pos]    = e;
                acks[pos]    = a;
                targets[pos] = t;
                depths[pos]  = d;
                count++;
            end
            if (lst) begin
                select_window();
                count = 0;
            end
        endfunction

        task check_result(sel_result_t got);
            sel_result_t want;

            if (pending.size() == 0) begin
                report($sformatf("unexpected result target %0h", got.target));
                return;
            end
            want = pending.pop_front();
            if (got.target !== want.target)
                report($sformatf("chosen_target %0h, want %0h", got.target, want.target));
            if (got.wbegin !== want.wbegin)
                report($sformatf("window_begin %0h, want %0h", got.wbegin, want.wbegin));
            if (got.wfinish !== want.wfinish)
                report($sformatf("window_finish %0h, want %0h", got.wfinish, want.wfinish));
            if (got.depth !== want.depth)
                report($sformatf("max_depth %0d, want %0d", got.depth, want.depth));
            if (got.found !== want.found)
                report($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.last !== want.last)
                report($sformatf("last_result %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [47:0] bid_open;
    logic [47:0] bid_end;
    logic [47:0] ack_estimate;
    logic [15:0] target_id;
    logic [9:0]  backlog;
    logic        last_bid;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [15:0] chosen_target;
    logic [47:0] window_begin;
    logic [48:0] window_finish;
    logic [9:0]  max_depth;
    logic        found;
    logic        last_result;

    bid_scoreboard sb;
    bit            no_idle;

    replica_bid_window_selector_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .bid_open        (bid_open),
        .bid_end         (bid_end),
        .ack_estimate    (ack_estimate),
        .target_id       (target_id),
        .backlog         (backlog),
        .last_bid        (last_bid),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .chosen_target   (chosen_target),
        .window_begin    (window_begin),
        .window_finish   (window_finish),
        .max_depth       (max_depth),
        .found           (found),
        .last_result     (last_result)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{chosen_target, window_begin, window_finish,
                              max_depth, found, last_result});
    end

    function automatic int gap_len();
        int p;

        p = $urandom_range(0, 99);
        if (no_idle || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one bid and hold it until accepted; start stays high on return
    task automatic send_bid(logic [47:0] s, logic [47:0] e, logic [47:0] a,
                            logic [15:0] t, logic [9:0] d, logic lst);
        int gap;

        gap = gap_len();
        @(negedge clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        bid_open     = s;
        bid_end      = e;
        ack_estimate = a;
        target_id    = t;
        backlog      = d;
        last_bid     = lst;
        start        = 1'b1;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_bid(s, e, a, t, d, lst);
    endtask

    // Let every expected result arrive and the block fall idle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random group: tidy ones cluster starts so windows comply
    task automatic send_group(int n, bit tidy, ref int sent);
        logic [47:0] base;
        logic [47:0] s;
        logic [47:0] e;
        logic [47:0] a;
        int          spread;
        logic        lst;

        base   = 48'({$urandom, $urandom});
        spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 60);
        for (int i = 0; i < n; i++) begin
            if (tidy) begin
                s   = base + $urandom_range(0, spread);
                e   = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom})
                      : s + $urandom_range(0, 400);
                a   = ($urandom_range(0, 2) == 0) ? 48'($urandom_range(0, 3))
                      : 48'({$urandom, $urandom});
                lst = (i == n - 1);
            end else begin
                s   = 48'({$urandom, $urandom});
                e   = 48'({$urandom, $urandom});
                a   = 48'({$urandom, $urandom});
                lst = (i == n - 1) || ($urandom_range(0, 5) == 0);
            end
            send_bid(s, e, a, 16'($urandom), 10'($urandom_range(0, 998)), lst);
            sent++;
            if (lst && !tidy)
                break;
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int n;

        sent    = 0;
        no_idle = ($urandom_range(0, 3) == 0);
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 10);
            send_group(n, $urandom_range(0, 4) != 0, sent);
            if (sent > items / 2 && sent < items / 2 + 12)
                no_idle = ~no_idle;
        end
        no_idle = 1'b0;
    endtask

    // Timeout
    initial
    begin
        #1000000;
        $display("replica_bid_window_selector_top_test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        sb           = new();
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        bid_open     = '0;
        bid_end      = '0;
        ack_estimate = '0;
        target_id    = '0;
        backlog      = '0;
        last_bid     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_REPLICA_COUNT;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Too few bids, with field extremes
        send_bid('1, '1, '1, 16'hFFFF, 10'd998, 1'b1);
        // Equal starts kept in arrival order, exactly three comply
        send_bid(48'd0, '1, 48'd0, 16'd0, 10'd0, 1'b0);
        send_bid(48'd0, '1, 48'd9, 16'd1, 10'd5, 1'b0);
        send_bid(48'd0, '1, 48'd3, 16'd2, 10'd7, 1'b1);
        // Four comply at one tick: ordered by ack estimate
        send_bid(48'd5, 48'd90, 48'd40, 16'd10, 10'd1, 1'b0);
        send_bid(48'd5, 48'd80, 48'd30, 16'd11, 10'd2, 1'b0);
        send_bid(48'd5, 48'd70, 48'd30, 16'd12, 10'd512, 1'b0);
        send_bid(48'd5, 48'd60, 48'd10, 16'd13, 10'd3, 1'b1);
        // Ends too early: too few comply
        send_bid(48'd20, 48'd5, 48'd1, 16'd20, 10'd1, 1'b0);
        send_bid(48'd0, 48'd5, 48'd2, 16'd21, 10'd2, 1'b0);
        send_bid(48'd10, 48'd5, 48'd3, 16'd22, 10'd3, 1'b1);

        random_phase(50);

        write_reg(CFG_TRANSFER_DURATION, 32'hFFFF_FFFF);
        write_reg(CFG_REPLICA_COUNT, 32'd1);
        random_phase(45);

        write_reg(CFG_TRANSFER_DURATION, 32'd30);
        write_reg(CFG_REPLICA_COUNT, 32'd8);
        random_phase(25);
        drain();
        random_phase(25);

        write_reg(CFG_REPLICA_COUNT, 32'd0);
        write_reg(CFG_TRANSFER_DURATION, 32'd0);
        random_phase(40);

        write_reg(CFG_REPLICA_COUNT, 32'hFFFF_FFFF);
        write_reg(CFG_TRANSFER_DURATION, $urandom);
        random_phase(40);

        write_reg(CFG_REPLICA_COUNT, 32'd5);
        write_reg(CFG_TRANSFER_DURATION, 32'd12);
        random_phase(90);

        drain();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("replica_bid_window_selector_top_test passed");
        else
            $display("replica_bid_window_selector_top_test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rbws_pkg.sv
hw/rtl/rbws_ctrl.sv
hw/rtl/rbws_dp.sv
hw/rtl/replica_bid_window_selector_top.sv
bench/replica_bid_window_selector_top_test.sv
